@@ hdl/ic_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the inversion counter.
// No dependencies; used by every module of the block.
package ic_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int ELEM_W       = 32;
  localparam int TOTAL_W      = 30;

  localparam logic [TOTAL_W:0]  INV_LIMIT = (TOTAL_W + 1)'(1000000000);
  localparam logic [ELEM_W-1:0] SIGN_BIAS = {1'b1, {(ELEM_W - 1){1'b0}}};
  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(MAX_ELEMENTS);

  // One request travelling down the cell row
  typedef struct packed {
    logic              vld;
    logic [ELEM_W-1:0] val;   // sign-flipped element, unsigned order
    logic              keep;  // element is stored, not dropped
    logic              last;
    logic              ovr;
    logic [CNT_W-1:0]  pos;   // elements of this array ahead of it
    logic [CNT_W-1:0]  gt;    // earlier elements found greater so far
  } ic_tok_t;

endpackage

@@ hdl/ic_cell.sv @@
`timescale 1ns / 1ps
// One compare cell of the row: holds one stored element and passes requests on.
// Depends on ic_pkg.
module ic_cell
  import ic_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic [CNT_W-1:0] idx_i,
  input  ic_tok_t          tok_i,
  output ic_tok_t          tok_o
);

  logic [ELEM_W-1:0] elem_q;
  ic_tok_t           tok_q;
  ic_tok_t           tok_d;
  logic              hit;
  logic              wr;

  always_comb begin
    hit   = tok_i.vld && tok_i.keep && (idx_i < tok_i.pos) && (elem_q > tok_i.val);
    wr    = adv_i && tok_i.vld && tok_i.keep && (tok_i.pos == idx_i);
    tok_d = tok_i;
    if (hit) begin
      tok_d.gt = tok_i.gt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q.vld <= 1'b0;
    end else if (adv_i) begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      elem_q <= tok_i.val;
    end
  end

  assign tok_o = tok_q;

endmodule

@@ hdl/ic_tally.sv @@
`timescale 1ns / 1ps
// Running pair count at the end of the cell row, limit check and result register.
// Depends on ic_pkg.
module ic_tally
  import ic_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  ic_tok_t            tok_i,
  output logic               out_valid_o,
  output logic [TOTAL_W-1:0] inversion_total_o,
  output logic               limit_reached_o,
  output logic               overrun_o
);

  logic [TOTAL_W-1:0] acc_q, acc_d, acc_nx;
  logic               lim_q, lim_d, lim_nx;
  logic               vld_q, vld_d;
  logic [TOTAL_W-1:0] tot_q, tot_d;
  logic               rlim_q, rlim_d;
  logic               rovr_q, rovr_d;
  logic [TOTAL_W:0]   sum;
  logic               take;

  always_comb begin
    take   = adv_i && tok_i.vld;
    sum    = {1'b0, acc_q} + (TOTAL_W + 1)'(tok_i.gt);
    acc_nx = acc_q;
    lim_nx = lim_q;
    if (!lim_q) begin
      if (sum >= INV_LIMIT) begin
        lim_nx = 1'b1;
      end else begin
        acc_nx = sum[TOTAL_W-1:0];
      end
    end

    acc_d  = acc_q;
    lim_d  = lim_q;
    vld_d  = vld_q;
    tot_d  = tot_q;
    rlim_d = rlim_q;
    rovr_d = rovr_q;
    if (adv_i) begin
      vld_d = 1'b0;
    end
    if (take) begin
      if (tok_i.last) begin
        vld_d  = 1'b1;
        tot_d  = lim_nx ? '0 : acc_nx;
        rlim_d = lim_nx;
        rovr_d = tok_i.ovr;
        acc_d  = '0;
        lim_d  = 1'b0;
      end else begin
        acc_d = acc_nx;
        lim_d = lim_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      lim_q <= 1'b0;
      vld_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      lim_q <= lim_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tot_q  <= tot_d;
    rlim_q <= rlim_d;
    rovr_q <= rovr_d;
  end

  assign out_valid_o       = vld_q;
  assign inversion_total_o = tot_q;
  assign limit_reached_o   = rlim_q;
  assign overrun_o         = rovr_q;

endmodule

@@ hdl/inversion_counter_top.sv @@
`timescale 1ns / 1ps
// Inversion counter top level: entry stage, row of compare cells, tally stage.
// Depends on ic_pkg, ic_cell and ic_tally.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-----------------------------------------
//   in      | input     | in_valid_i, in_stall_o | element_value_i, is_last_i
//   out     | output    | out_valid_o, out_stall_i | inversion_total_o, limit_reached_o, overrun_o
//
// One element is taken every cycle while no result is held; each request walks the row of
// MAX_ELEMENTS cells, one cell a cycle while the row advances, and the tally stage registers
// the result of an array once the last request of that array leaves the row.
// Requests of consecutive arrays overlap in the row.
// Reset clears the request valid bits, counters and flags; stored elements need none.
// A held result stalls the whole row and the input together.
module inversion_counter_top
  import ic_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ELEM_W-1:0]  element_value_i,
  input  logic               is_last_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [TOTAL_W-1:0] inversion_total_o,
  output logic               limit_reached_o,
  output logic               overrun_o
);

  logic             adv;
  logic             acc_in;
  logic             drop;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             ovr_q, ovr_d;
  ic_tok_t          in_tok;
  ic_tok_t          tok [0:MAX_ELEMENTS];

  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;
  assign acc_in     = in_valid_i && !in_stall_o;
  assign drop       = (cnt_q == CNT_FULL);
  assign tok[0]     = in_tok;

  always_comb begin
    in_tok.vld  = acc_in && (!drop || is_last_i);
    in_tok.val  = element_value_i ^ SIGN_BIAS;
    in_tok.keep = !drop;
    in_tok.last = is_last_i;
    in_tok.ovr  = ovr_q || drop;
    in_tok.pos  = cnt_q;
    in_tok.gt   = '0;

    cnt_d = cnt_q;
    ovr_d = ovr_q;
    if (acc_in) begin
      if (is_last_i) begin
        cnt_d = '0;
        ovr_d = 1'b0;
      end else begin
        ovr_d = ovr_q || drop;
        if (!drop) begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ovr_q <= ovr_d;
    end
  end

  for (genvar k = 0; k < MAX_ELEMENTS; k++) begin : g_cell
    ic_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .idx_i  (CNT_W'(k)),
      .tok_i  (tok[k]),
      .tok_o  (tok[k+1])
    );
  end

  ic_tally u_tally (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .adv_i             (adv),
    .tok_i             (tok[MAX_ELEMENTS]),
    .out_valid_o       (out_valid_o),
    .inversion_total_o (inversion_total_o),
    .limit_reached_o   (limit_reached_o),
    .overrun_o         (overrun_o)
  );

  a_lim_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && limit_reached_o |-> inversion_total_o == '0)
    else $error("total not cleared on limit");

  a_total_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> {1'b0, inversion_total_o} < INV_LIMIT)
    else $error("total beyond limit");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_FULL)
    else $error("element count beyond depth");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_in && is_last_i |=> cnt_q == '0 && !ovr_q)
    else $error("entry state not cleared after last element");

endmodule

@@ verif/inversion_counter_top_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for inversion_counter_top: streams arrays of signed elements,
// predicts the inverted-pair total of each array and checks every result.
// Depends on ic_pkg and the inversion_counter_top RTL.
module inversion_counter_top_test;
  import ic_pkg::*;

  typedef struct {
    logic [TOTAL_W-1:0] total;
    logic               at_limit;
    logic               dropped;
  } array_total_t;

  class inversion_tally;
    logic signed [ELEM_W-1:0] kept [MAX_ELEMENTS];
    int unsigned              kept_count;
    logic [TOTAL_W-1:0]       pairs;
    bit                       at_limit;
    bit                       dropped;
    array_total_t             pending [$];
    int                       errors;

    function new();
      errors = 0;
      clear_array();
    endfunction

    function void clear_array();
      kept_count = 0;
      pairs      = '0;
      at_limit   = 1'b0;
      dropped    = 1'b0;
    endfunction

    // Count earlier kept elements strictly above the new one; queue a total on last
    function void add_element(logic [ELEM_W-1:0] value, logic last);
      int unsigned  greater;
      array_total_t t;
      greater = 0;
      if (kept_count >= MAX_ELEMENTS) begin
        dropped = 1'b1;
      end else begin
        if (!at_limit) begin
          for (int k = 0; k < kept_count; k++) begin
            if (kept[k] > $signed(value)) greater++;
          end
          if (longint'(pairs) + longint'(greater) >= longint'(INV_LIMIT)) begin
            at_limit = 1'b1;
          end else begin
            pairs = pairs + TOTAL_W'(greater);
          end
        end
        kept[kept_count] = value;
        kept_count++;
      end
      if (last) begin
        t.total    = at_limit ? '0 : pairs;
        t.at_limit = at_limit;
        t.dropped  = dropped;
        pending.push_back(t);
        clear_array();
      end
    endfunction

    function void compare_total(logic [TOTAL_W-1:0] total, logic lim, logic ovr);
      array_total_t t;
      if (pending.size() == 0) begin
        $error("result with no request pending: total %0d", total);
        errors++;
        return;
      end
      t = pending.pop_front();
      if (total !== t.total) begin
        $error("inversion_total: expected %0d, got %0d", t.total, total);
        errors++;
      end
      if (lim !== t.at_limit) begin
        $error("limit_reached: expected %0b, got %0b", t.at_limit, lim);
        errors++;
      end
      if (ovr !== t.dropped) begin
        $error("overrun: expected %0b, got %0b", t.dropped, ovr);
        errors++;
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 300000;
  localparam int ITEM_TARGET = 1350;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall_o;
  logic [ELEM_W-1:0]  element_value = '0;
  logic               is_last = 1'b0;
  logic               out_valid_o;
  logic               out_stall = 1'b0;
  logic [TOTAL_W-1:0] inversion_total_o;
  logic               limit_reached_o;
  logic               overrun_o;

  inversion_tally tally;
  bit             no_idle = 1'b0;
  int             items_sent = 0;
  int             cycle_count = 0;

  inversion_counter_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall_o),
    .element_value_i  (element_value),
    .is_last_i        (is_last),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall),
    .inversion_total_o(inversion_total_o),
    .limit_reached_o  (limit_reached_o),
    .overrun_o        (overrun_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall <= no_idle ? 1'b0 : ($urandom_range(0, 99) < 27);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      tally.compare_total(inversion_total_o, limit_reached_o, overrun_o);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("inversion_counter_top_test: errors");
      $finish;
    end
  end

  task automatic send_element(input logic [ELEM_W-1:0] value, input logic last);
    while (!no_idle && $urandom_range(0, 99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid      <= 1'b1;
    element_value <= value;
    is_last       <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tally.add_element(value, last);
    items_sent++;
  endtask

  task automatic send_list(input int values [$]);
    foreach (values[i]) send_element(values[i], i == values.size() - 1);
  endtask

  function automatic logic [ELEM_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0: return ELEM_W'($urandom_range(0, 8)) - ELEM_W'(4);
      1: begin
        case ($urandom_range(0, 3))
          0: return SIGN_BIAS;
          1: return ~SIGN_BIAS;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_array(input int len);
    for (int i = 0; i < len; i++) send_element(pick_value(), i == len - 1);
  endtask

  // Hold the input until every pending total has come back
  task automatic drain_totals();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (tally.pending.size() != 0);
  endtask

  initial begin
    tally = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_list('{32'h8000_0000});
    send_list('{32'h7FFF_FFFF, 32'h8000_0000});
    send_list('{32'h8000_0000, 32'h7FFF_FFFF});
    send_list('{5, 5, 5});
    send_list('{0, -1});
    send_list('{-1, 0});
    send_list('{3, 2, 1, 0, -1, -2});
    send_list('{1, -1, 1, -1});
    drain_totals();

    while (items_sent < 160) send_random_array($urandom_range(1, 10));

    // Overfill one array at full rate so the tail elements are dropped
    no_idle = 1'b1;
    send_random_array(MAX_ELEMENTS + $urandom_range(1, 6));
    no_idle = 1'b0;
    drain_totals();

    while (items_sent < ITEM_TARGET) send_random_array($urandom_range(1, 10));
    in_valid <= 1'b0;
    while (tally.pending.size() != 0) @(posedge clk_i);
    repeat (MAX_ELEMENTS + 16) @(posedge clk_i);

    if (tally.errors == 0 && tally.pending.size() == 0) begin
      $display("inversion_counter_top_test: clean");
    end else begin
      $display("inversion_counter_top_test: errors");
    end
    $finish;
  end

endmodule
